[design/rsra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsra_pkg
// Shared types, codes and constants of the radio state residency accounting
// block: radio states, MAC and PHY codes, counter indices, switch times.
// ----------------------------------------------------------------------------
package rsra_pkg;

    localparam int TIME_W    = 48;
    localparam int NUM_CNT   = 22;
    localparam int CNT_IDX_W = 5;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int SW_W      = 16;
    localparam int CALC_W    = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef logic [CNT_IDX_W-1:0] cnt_idx_t;
    typedef logic [SW_W-1:0]      sw_us_t;
    typedef logic [NUM_CFG-1:0][SW_W-1:0] cfg_bank_t;

    // radio energy state, one-hot
    typedef enum logic [3:0] {
        ST_SLEEP = 4'b0001,
        ST_RX    = 4'b0010,
        ST_TX    = 4'b0100,
        ST_IDLE  = 4'b1000
    } radio_st_t;

    localparam logic [1:0] CODE_SLEEP = 2'd0;
    localparam logic [1:0] CODE_RX    = 2'd1;
    localparam logic [1:0] CODE_TX    = 2'd2;
    localparam logic [1:0] CODE_IDLE  = 2'd3;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_CALC   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [3:0] MAC_IDLE     = 4'd1;
    localparam logic [3:0] MAC_BACKOFF  = 4'd2;
    localparam logic [3:0] MAC_CCA      = 4'd3;
    localparam logic [3:0] MAC_TXFRAME  = 4'd4;
    localparam logic [3:0] MAC_WAITACK  = 4'd5;
    localparam logic [3:0] MAC_WAITSIFS = 4'd6;
    localparam logic [3:0] MAC_TXACK    = 4'd7;
    localparam logic [3:0] MAC_KEEP     = 4'd8;

    localparam logic [2:0] PHY_RX    = 3'd0;
    localparam logic [2:0] PHY_TX    = 3'd1;
    localparam logic [2:0] PHY_SLEEP = 3'd2;
    localparam logic [2:0] PHY_KEEP  = 3'd4;

    // configuration register indices
    localparam int CFG_SLEEP_TO_RX   = 0;
    localparam int CFG_SLEEP_TO_IDLE = 1;
    localparam int CFG_RX_TO_TX      = 2;
    localparam int CFG_RX_TO_SLEEP   = 3;
    localparam int CFG_TX_TO_RX      = 4;
    localparam int CFG_TX_TO_SLEEP   = 5;
    localparam int CFG_IDLE_TO_TX    = 6;
    localparam int CFG_IDLE_TO_SLEEP = 7;

    localparam sw_us_t RST_SLEEP_TO_RX   = 16'd0;
    localparam sw_us_t RST_SLEEP_TO_IDLE = 16'd1880;
    localparam sw_us_t RST_RX_TO_TX      = 16'd0;
    localparam sw_us_t RST_RX_TO_SLEEP   = 16'd0;
    localparam sw_us_t RST_TX_TO_RX      = 16'd0;
    localparam sw_us_t RST_TX_TO_SLEEP   = 16'd0;
    localparam sw_us_t RST_IDLE_TO_TX    = 16'd192;
    localparam sw_us_t RST_IDLE_TO_SLEEP = 16'd940;

    localparam sw_us_t TX_TO_IDLE_US     = 16'd192;
    localparam sw_us_t RX_IDLE_SWITCH_US = 16'd0;

    // counter indices
    localparam cnt_idx_t CNT_SLEEP         = 5'd0;
    localparam cnt_idx_t CNT_TX            = 5'd1;
    localparam cnt_idx_t CNT_RX            = 5'd2;
    localparam cnt_idx_t CNT_IDLE          = 5'd3;
    localparam cnt_idx_t CNT_CCA           = 5'd4;
    localparam cnt_idx_t CNT_BACKOFF       = 5'd5;
    localparam cnt_idx_t CNT_RX_TO_SLEEP   = 5'd6;
    localparam cnt_idx_t CNT_RX_TO_TX      = 5'd7;
    localparam cnt_idx_t CNT_RX_TO_IDLE    = 5'd8;
    localparam cnt_idx_t CNT_SLEEP_TO_RX   = 5'd9;
    localparam cnt_idx_t CNT_SLEEP_TO_IDLE = 5'd10;
    localparam cnt_idx_t CNT_TX_TO_SLEEP   = 5'd11;
    localparam cnt_idx_t CNT_TX_TO_RX      = 5'd12;
    localparam cnt_idx_t CNT_TX_TO_IDLE    = 5'd13;
    localparam cnt_idx_t CNT_IDLE_TO_RX    = 5'd14;
    localparam cnt_idx_t CNT_IDLE_TO_TX    = 5'd15;
    localparam cnt_idx_t CNT_IDLE_TO_SLEEP = 5'd16;
    localparam cnt_idx_t CNT_CALC          = 5'd17;
    localparam cnt_idx_t CNT_MCU_ON        = 5'd18;
    localparam cnt_idx_t CNT_MCU_OFF       = 5'd19;
    localparam cnt_idx_t CNT_MCU_ON_SLEEP  = 5'd20;
    localparam cnt_idx_t CNT_MCU_SLEEP_ON  = 5'd21;

    // result of the transition decode
    typedef struct packed {
        radio_st_t next_st;
        logic      changed;
        logic      credit_sw;
        cnt_idx_t  sw_cnt;
        cnt_idx_t  mcu_cnt;
        sw_us_t    sw_us;
    } trans_t;

    function automatic logic [1:0] st_code(input radio_st_t st);
        logic [1:0] code;
        code = CODE_RX;
        unique case (st)
            ST_SLEEP: code = CODE_SLEEP;
            ST_RX:    code = CODE_RX;
            ST_TX:    code = CODE_TX;
            ST_IDLE:  code = CODE_IDLE;
            default:  code = CODE_RX;
        endcase
        return code;
    endfunction

endpackage

[design/radio_state_residency_accounting.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_state_residency_accounting
// Tracks the radio energy state and accumulates residency, transition and
// MCU time counters; serves calculating-time credits and counter reads.
// ----------------------------------------------------------------------------
//  channel   ports            direction  carries
//  s_        valid/ready      in         request: mode, time, MAC/PHY, amount
//  m_        valid/ready      out        state, resume stamp, counter value
//  cfg_      valid/ready      in         switch time register writes
//
//  One request per cycle sustained while the result is taken; a request passes
//  the input register, then the result register. The rate is set by the update
//  of the 22-counter bank and the stored stamp, done as one pass per request.
//  Synchronous active-low reset restores switch times, state and counters.
//  A stalled result holds; a new request is still taken into the input
//  register while the result waits, but only if that register is empty.
// ----------------------------------------------------------------------------
module radio_state_residency_accounting (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [rsra_pkg::TIME_W-1:0] s_now_us,
    input  logic                        s_transmitting,
    input  logic [3:0]                  s_mac_state,
    input  logic [2:0]                  s_phy_state,
    input  logic [rsra_pkg::CALC_W-1:0] s_calc_amount_us,
    input  logic [4:0]                  s_counter_index,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_radio_state,
    output logic [rsra_pkg::TIME_W-1:0] m_resume_stamp_us,
    output logic [rsra_pkg::TIME_W-1:0] m_counter_value,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsra_pkg::SW_W-1:0]      cfg_data
);

    localparam int TW = rsra_pkg::TIME_W;

    // input register
    logic                        in_valid_reg;
    logic [1:0]                  mode_reg;
    logic [TW-1:0]               now_reg;
    logic                        tx_reg;
    logic [3:0]                  mac_reg;
    logic [2:0]                  phy_reg;
    logic [rsra_pkg::CALC_W-1:0] calc_reg;
    rsra_pkg::cnt_idx_t          idx_reg;

    // block state
    rsra_pkg::cfg_bank_t  cfg_reg;
    rsra_pkg::radio_st_t  st_reg;
    rsra_pkg::radio_st_t  st_next;
    logic [3:0]           last_mac_reg;
    logic [3:0]           last_mac_next;
    logic [2:0]           last_phy_reg;
    logic [2:0]           last_phy_next;
    logic [TW-1:0]        stamp_reg;
    logic [TW-1:0]        stamp_next;
    logic [TW-1:0]        cnt_reg  [rsra_pkg::NUM_CNT];
    logic [TW-1:0]        cnt_next [rsra_pkg::NUM_CNT];

    // result register
    logic                 m_valid_reg;
    logic [1:0]           radio_state_reg;
    logic [TW-1:0]        resume_reg;
    logic [TW-1:0]        value_reg;
    logic [TW-1:0]        value_next;

    logic                 advance;
    logic [3:0]           mac_eff;
    logic [2:0]           phy_eff;
    logic [TW-1:0]        elapsed;
    logic [TW:0]          stamp_sum;
    rsra_pkg::trans_t     trans;
    rsra_pkg::cnt_idx_t   el_cnt;
    rsra_pkg::cnt_idx_t   mcu_el_cnt;
    rsra_pkg::cnt_idx_t   sub_cnt;
    logic [TW:0]          add_amt [rsra_pkg::NUM_CNT];
    logic [TW+1:0]        cnt_sum [rsra_pkg::NUM_CNT];
    logic [TW-1:0]        calc_ext;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid           = m_valid_reg;
    assign m_radio_state     = radio_state_reg;
    assign m_resume_stamp_us = resume_reg;
    assign m_counter_value   = value_reg;

    assign mac_eff  = (mac_reg == rsra_pkg::MAC_KEEP) ? last_mac_reg : mac_reg;
    assign phy_eff  = (phy_reg == rsra_pkg::PHY_KEEP) ? last_phy_reg : phy_reg;
    assign elapsed  = (now_reg >= stamp_reg) ? (now_reg - stamp_reg) : '0;
    assign calc_ext = TW'(calc_reg);

    rsra_trans u_trans (
        .prev_st      (st_reg),
        .transmitting (tx_reg),
        .mac_state    (mac_eff),
        .phy_state    (phy_eff),
        .cfg          (cfg_reg),
        .trans        (trans)
    );

    // counters credited with the elapsed residency
    always_comb begin
        el_cnt     = rsra_pkg::CNT_RX;
        mcu_el_cnt = rsra_pkg::CNT_MCU_ON;
        unique case (st_reg)
            rsra_pkg::ST_SLEEP: begin
                el_cnt     = rsra_pkg::CNT_SLEEP;
                mcu_el_cnt = rsra_pkg::CNT_MCU_OFF;
            end
            rsra_pkg::ST_RX: begin
                el_cnt = (last_mac_reg == rsra_pkg::MAC_CCA) ?
                         rsra_pkg::CNT_CCA : rsra_pkg::CNT_RX;
            end
            rsra_pkg::ST_TX: begin
                el_cnt = rsra_pkg::CNT_TX;
            end
            rsra_pkg::ST_IDLE: begin
                el_cnt = (last_mac_reg == rsra_pkg::MAC_BACKOFF) ?
                         rsra_pkg::CNT_BACKOFF : rsra_pkg::CNT_IDLE;
            end
            default: el_cnt = rsra_pkg::CNT_RX;
        endcase
    end

    assign sub_cnt   = (st_reg == rsra_pkg::ST_SLEEP) ?
                       rsra_pkg::CNT_MCU_ON_SLEEP : rsra_pkg::CNT_MCU_ON;
    assign stamp_sum = {1'b0, now_reg} + (TW + 1)'(trans.sw_us);

    always_comb begin
        st_next       = st_reg;
        last_mac_next = last_mac_reg;
        last_phy_next = last_phy_reg;
        stamp_next    = stamp_reg;
        value_next    = '0;
        for (int i = 0; i < rsra_pkg::NUM_CNT; i++) begin
            add_amt[i]  = '0;
            cnt_sum[i]  = '0;
            cnt_next[i] = cnt_reg[i];
        end
        case (mode_reg)
            rsra_pkg::MODE_UPDATE: begin
                st_next       = trans.next_st;
                last_mac_next = mac_eff;
                last_phy_next = phy_eff;
                if (!trans.changed) begin
                    stamp_next = now_reg;
                end else begin
                    stamp_next = stamp_sum[TW] ? rsra_pkg::TIME_MAX : stamp_sum[TW-1:0];
                end
                for (int i = 0; i < rsra_pkg::NUM_CNT; i++) begin
                    if (rsra_pkg::cnt_idx_t'(i) == el_cnt
                        || rsra_pkg::cnt_idx_t'(i) == mcu_el_cnt) begin
                        add_amt[i] = {1'b0, elapsed};
                    end
                    if (trans.credit_sw && (rsra_pkg::cnt_idx_t'(i) == trans.sw_cnt
                        || rsra_pkg::cnt_idx_t'(i) == trans.mcu_cnt)) begin
                        add_amt[i] = add_amt[i] + (TW + 1)'(trans.sw_us);
                    end
                    cnt_sum[i]  = {2'b00, cnt_reg[i]} + {1'b0, add_amt[i]};
                    cnt_next[i] = (cnt_sum[i][TW+1:TW] != 2'b00) ?
                                  rsra_pkg::TIME_MAX : cnt_sum[i][TW-1:0];
                end
            end
            rsra_pkg::MODE_CALC: begin
                for (int i = 0; i < rsra_pkg::NUM_CNT; i++) begin
                    if (rsra_pkg::cnt_idx_t'(i) == rsra_pkg::CNT_CALC) begin
                        cnt_sum[i]  = {2'b00, cnt_reg[i]} + {2'b00, calc_ext};
                        cnt_next[i] = (cnt_sum[i][TW+1:TW] != 2'b00) ?
                                      rsra_pkg::TIME_MAX : cnt_sum[i][TW-1:0];
                    end else if (rsra_pkg::cnt_idx_t'(i) == sub_cnt) begin
                        cnt_next[i] = (cnt_reg[i] > calc_ext) ? (cnt_reg[i] - calc_ext) : '0;
                    end
                end
            end
            rsra_pkg::MODE_READ: begin
                if (idx_reg < rsra_pkg::cnt_idx_t'(rsra_pkg::NUM_CNT)) begin
                    value_next = cnt_reg[idx_reg];
                end
            end
            default: value_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[rsra_pkg::CFG_SLEEP_TO_RX]   <= rsra_pkg::RST_SLEEP_TO_RX;
            cfg_reg[rsra_pkg::CFG_SLEEP_TO_IDLE] <= rsra_pkg::RST_SLEEP_TO_IDLE;
            cfg_reg[rsra_pkg::CFG_RX_TO_TX]      <= rsra_pkg::RST_RX_TO_TX;
            cfg_reg[rsra_pkg::CFG_RX_TO_SLEEP]   <= rsra_pkg::RST_RX_TO_SLEEP;
            cfg_reg[rsra_pkg::CFG_TX_TO_RX]      <= rsra_pkg::RST_TX_TO_RX;
            cfg_reg[rsra_pkg::CFG_TX_TO_SLEEP]   <= rsra_pkg::RST_TX_TO_SLEEP;
            cfg_reg[rsra_pkg::CFG_IDLE_TO_TX]    <= rsra_pkg::RST_IDLE_TO_TX;
            cfg_reg[rsra_pkg::CFG_IDLE_TO_SLEEP] <= rsra_pkg::RST_IDLE_TO_SLEEP;
        end else if (cfg_valid && cfg_ready
                     && cfg_index < rsra_pkg::CFG_IDX_W'(rsra_pkg::NUM_CFG)) begin
            cfg_reg[cfg_index[$clog2(rsra_pkg::NUM_CFG)-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            now_reg  <= s_now_us;
            tx_reg   <= s_transmitting;
            mac_reg  <= s_mac_state;
            phy_reg  <= s_phy_state;
            calc_reg <= s_calc_amount_us;
            idx_reg  <= s_counter_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= rsra_pkg::ST_RX;
            last_mac_reg <= rsra_pkg::MAC_IDLE;
            last_phy_reg <= rsra_pkg::PHY_RX;
            stamp_reg    <= '0;
            for (int i = 0; i < rsra_pkg::NUM_CNT; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            st_reg       <= st_next;
            last_mac_reg <= last_mac_next;
            last_phy_reg <= last_phy_next;
            stamp_reg    <= stamp_next;
            for (int i = 0; i < rsra_pkg::NUM_CNT; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            radio_state_reg <= rsra_pkg::st_code(st_next);
            resume_reg      <= stamp_next;
            value_reg       <= value_next;
        end
    end

endmodule

[design/rsra_trans.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsra_trans
// Next radio state from the transition rules, and the switch time and
// counters charged for a state change.
// ----------------------------------------------------------------------------
module rsra_trans (
    input  rsra_pkg::radio_st_t prev_st,
    input  logic                transmitting,
    input  logic [3:0]          mac_state,
    input  logic [2:0]          phy_state,
    input  rsra_pkg::cfg_bank_t cfg,
    output rsra_pkg::trans_t    trans
);

    logic idle_rx;
    logic back_rx;
    logic sifs_tx;
    rsra_pkg::radio_st_t nxt;

    assign idle_rx = (mac_state == rsra_pkg::MAC_IDLE) && (phy_state == rsra_pkg::PHY_RX);
    assign back_rx = (mac_state == rsra_pkg::MAC_BACKOFF) && (phy_state == rsra_pkg::PHY_RX);
    assign sifs_tx = (mac_state == rsra_pkg::MAC_WAITSIFS) && (phy_state == rsra_pkg::PHY_TX);

    always_comb begin
        nxt = prev_st;
        unique case (prev_st)
            rsra_pkg::ST_SLEEP: begin
                if (phy_state == rsra_pkg::PHY_RX) begin
                    nxt = transmitting ? rsra_pkg::ST_IDLE : rsra_pkg::ST_RX;
                end else if (phy_state == rsra_pkg::PHY_SLEEP) begin
                    nxt = rsra_pkg::ST_SLEEP;
                end
            end
            rsra_pkg::ST_RX: begin
                if (phy_state == rsra_pkg::PHY_SLEEP) begin
                    nxt = rsra_pkg::ST_SLEEP;
                end else if (!transmitting && idle_rx) begin
                    nxt = rsra_pkg::ST_RX;
                end else if (transmitting && (back_rx || sifs_tx || idle_rx)) begin
                    nxt = rsra_pkg::ST_IDLE;
                end else if (transmitting && mac_state == rsra_pkg::MAC_TXFRAME
                             && phy_state == rsra_pkg::PHY_TX) begin
                    nxt = rsra_pkg::ST_TX;
                end
            end
            rsra_pkg::ST_TX: begin
                if (phy_state == rsra_pkg::PHY_SLEEP) begin
                    nxt = rsra_pkg::ST_SLEEP;
                end else if (!transmitting && mac_state == rsra_pkg::MAC_WAITACK
                             && phy_state == rsra_pkg::PHY_RX) begin
                    nxt = rsra_pkg::ST_RX;
                end else if (transmitting && (idle_rx || back_rx)) begin
                    nxt = rsra_pkg::ST_IDLE;
                end
            end
            rsra_pkg::ST_IDLE: begin
                if (phy_state == rsra_pkg::PHY_SLEEP) begin
                    nxt = rsra_pkg::ST_SLEEP;
                end else if (!transmitting && idle_rx) begin
                    nxt = rsra_pkg::ST_RX;
                end else if (transmitting && (back_rx || sifs_tx || idle_rx)) begin
                    nxt = rsra_pkg::ST_IDLE;
                end else if (transmitting && mac_state == rsra_pkg::MAC_TXACK
                             && phy_state == rsra_pkg::PHY_TX) begin
                    nxt = rsra_pkg::ST_TX;
                end else if (transmitting && mac_state == rsra_pkg::MAC_CCA
                             && phy_state == rsra_pkg::PHY_RX) begin
                    nxt = rsra_pkg::ST_RX;
                end
            end
            default: nxt = prev_st;
        endcase
    end

    always_comb begin
        trans.next_st   = nxt;
        trans.changed   = (nxt != prev_st);
        trans.credit_sw = trans.changed;
        trans.sw_cnt    = rsra_pkg::CNT_SLEEP;
        trans.mcu_cnt   = rsra_pkg::CNT_MCU_ON;
        trans.sw_us     = '0;
        unique case ({prev_st, nxt})
            {rsra_pkg::ST_RX, rsra_pkg::ST_SLEEP}: begin
                trans.sw_cnt  = rsra_pkg::CNT_RX_TO_SLEEP;
                trans.sw_us   = cfg[rsra_pkg::CFG_RX_TO_SLEEP];
                trans.mcu_cnt = rsra_pkg::CNT_MCU_ON_SLEEP;
            end
            {rsra_pkg::ST_TX, rsra_pkg::ST_SLEEP}: begin
                trans.sw_cnt  = rsra_pkg::CNT_TX_TO_SLEEP;
                trans.sw_us   = cfg[rsra_pkg::CFG_TX_TO_SLEEP];
                trans.mcu_cnt = rsra_pkg::CNT_MCU_ON_SLEEP;
            end
            {rsra_pkg::ST_IDLE, rsra_pkg::ST_SLEEP}: begin
                trans.sw_cnt  = rsra_pkg::CNT_IDLE_TO_SLEEP;
                trans.sw_us   = cfg[rsra_pkg::CFG_IDLE_TO_SLEEP];
                trans.mcu_cnt = rsra_pkg::CNT_MCU_ON_SLEEP;
            end
            {rsra_pkg::ST_SLEEP, rsra_pkg::ST_RX}: begin
                trans.sw_cnt  = rsra_pkg::CNT_SLEEP_TO_RX;
                trans.sw_us   = cfg[rsra_pkg::CFG_SLEEP_TO_RX];
                trans.mcu_cnt = rsra_pkg::CNT_MCU_SLEEP_ON;
            end
            {rsra_pkg::ST_TX, rsra_pkg::ST_RX}: begin
                trans.sw_cnt = rsra_pkg::CNT_TX_TO_RX;
                trans.sw_us  = cfg[rsra_pkg::CFG_TX_TO_RX];
            end
            {rsra_pkg::ST_IDLE, rsra_pkg::ST_RX}: begin
                trans.sw_cnt = rsra_pkg::CNT_IDLE_TO_RX;
                trans.sw_us  = rsra_pkg::RX_IDLE_SWITCH_US;
            end
            {rsra_pkg::ST_RX, rsra_pkg::ST_TX}: begin
                trans.sw_cnt = rsra_pkg::CNT_RX_TO_TX;
                trans.sw_us  = cfg[rsra_pkg::CFG_RX_TO_TX];
            end
            {rsra_pkg::ST_IDLE, rsra_pkg::ST_TX}: begin
                trans.sw_cnt = rsra_pkg::CNT_IDLE_TO_TX;
                trans.sw_us  = cfg[rsra_pkg::CFG_IDLE_TO_TX];
            end
            {rsra_pkg::ST_SLEEP, rsra_pkg::ST_IDLE}: begin
                trans.sw_cnt  = rsra_pkg::CNT_SLEEP_TO_IDLE;
                trans.sw_us   = cfg[rsra_pkg::CFG_SLEEP_TO_IDLE];
                trans.mcu_cnt = rsra_pkg::CNT_MCU_SLEEP_ON;
            end
            {rsra_pkg::ST_TX, rsra_pkg::ST_IDLE}: begin
                trans.sw_cnt = rsra_pkg::CNT_TX_TO_IDLE;
                trans.sw_us  = rsra_pkg::TX_TO_IDLE_US;
            end
            {rsra_pkg::ST_RX, rsra_pkg::ST_IDLE}: begin
                trans.sw_cnt = rsra_pkg::CNT_RX_TO_IDLE;
                trans.sw_us  = rsra_pkg::RX_IDLE_SWITCH_US;
            end
            default: begin
                // no state change, or sleep to transmit: nothing charged
                trans.credit_sw = 1'b0;
            end
        endcase
    end

endmodule
